// ===== hdl/fdmm_pkg.sv =====
// Shared constants, register codes and arithmetic helpers for the motion mask block.
`default_nettype none

package fdmm_pkg;

	// Frame geometry limits
	localparam int MAX_WIDTH  = 640;
	localparam int MAX_HEIGHT = 480;
	localparam int MIN_DIM    = 3;

	// Field widths
	localparam int PIX_W = 8;
	localparam int COL_W = 10;
	localparam int ROW_W = 9;

	// Store geometry
	localparam int PREV_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int PREV_AW    = $clog2(PREV_DEPTH);
	localparam int LINE_DEPTH = MAX_WIDTH;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

	// Register reset values
	localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd30;
	localparam logic [COL_W-1:0] WIDTH_RESET     = COL_W'(MAX_WIDTH);
	localparam logic [ROW_W-1:0] HEIGHT_RESET    = ROW_W'(MAX_HEIGHT);

	// Item kinds carried in tuser
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// Stream widths
	localparam int S_DATA_W = 8;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 24;

	// Clamp a written width into the supported range
	function automatic logic [COL_W-1:0] clamp_width(input logic [COL_W-1:0] v);
		logic [COL_W-1:0] res;
		res = v;
		if (v < COL_W'(MIN_DIM))
			res = COL_W'(MIN_DIM);
		else if (v > COL_W'(MAX_WIDTH))
			res = COL_W'(MAX_WIDTH);
		return res;
	endfunction

	// Clamp a written height into the supported range
	function automatic logic [ROW_W-1:0] clamp_height(input logic [ROW_W-1:0] v);
		logic [ROW_W-1:0] res;
		res = v;
		if (v < ROW_W'(MIN_DIM))
			res = ROW_W'(MIN_DIM);
		else if (v > ROW_W'(MAX_HEIGHT))
			res = ROW_W'(MAX_HEIGHT);
		return res;
	endfunction

	// Linear address of a pixel in the previous-frame store
	function automatic logic [PREV_AW-1:0] prev_addr(input logic [ROW_W-1:0] r,
			input logic [COL_W-1:0] c);
		return PREV_AW'(r) * PREV_AW'(MAX_WIDTH) + PREV_AW'(c);
	endfunction

	// Vertical [1,2,1]/4, round half to even
	function automatic logic [PIX_W:0] smooth(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c);
		logic [PIX_W+1:0] s;
		logic [PIX_W-1:0] q;
		logic             up;
		s  = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
		q  = s[PIX_W+1:2];
		up = (s[1:0] == 2'd3) || ((s[1:0] == 2'd2) && q[0]);
		return {1'b0, q} + {{PIX_W{1'b0}}, up};
	endfunction

endpackage

`default_nettype wire

// ===== hdl/fdmm_ram.sv =====
// Generic single-clock RAM: one write port, one registered read port, write-through on collision.
`default_nettype none

module fdmm_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 640
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [$clog2(DEPTH)-1:0]  waddr,
	input  wire logic [DATA_W-1:0]         wdata,
	input  wire logic                      re,
	input  wire logic [$clog2(DEPTH)-1:0]  raddr,
	output logic      [DATA_W-1:0]         rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// Registered read; a write to the same address in the same cycle is passed through
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr))
				rdata <= wdata;
			else
				rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/frame_difference_motion_mask.sv =====
// Top level of the frame-difference motion mask.
`default_nettype none

// Red pixels arrive in raster order on the s_ group, one transfer per cycle at full rate.
// Each pixel is differenced against the stored previous frame and smoothed vertically with
// [1,2,1]/4; the motion bit for row r-1 appears as the pixel of row r passes, so results lag
// by one row, and the last row is pushed out by drain ticks (tuser kind = 1). The first frame
// after reset, or after a write to frame_width or frame_height, gives no results. Each result
// passes stage 1 and the output register: the store reads are registered at the input transfer
// together with the input register, and the difference, filter and threshold then load the
// output register when stage 1 advances. The block sustains one item per clock; it stalls
// only while a finished result is held up by m_tready. Stores start undefined and need no
// clearing pass.
module frame_difference_motion_mask (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [fdmm_pkg::S_DATA_W-1:0]     s_tdata,   // [7:0] red_value
	input  wire logic [fdmm_pkg::S_USER_W-1:0]     s_tuser,   // [0] kind, [1] frame_start
	// Result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [fdmm_pkg::M_DATA_W-1:0]     m_tdata,   // [0] motion, [10:1] column,
	                                                          // [19:11] row, [23:20] zero
	output logic                                   m_tlast,   // last_of_frame
	// Configuration writes
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [fdmm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fdmm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int PW  = fdmm_pkg::PIX_W;
	localparam int CW  = fdmm_pkg::COL_W;
	localparam int RW  = fdmm_pkg::ROW_W;
	localparam int PAW = fdmm_pkg::PREV_AW;
	localparam int LAW = fdmm_pkg::LINE_AW;

	// Configuration registers
	logic [PW-1:0] threshold_q;
	logic [CW-1:0] width_q;
	logic [RW-1:0] height_q;

	// Sequencing state
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic          have_prev_q, have_prev_d;
	logic          diff_frame_q, diff_frame_d;
	logic          drain_act_q, drain_act_d;
	logic [CW-1:0] drain_cnt_q, drain_cnt_d;

	// Stage 1 (store reads in flight)
	logic           valid_s1;
	logic           kind_s1;
	logic [PW-1:0]  red_s1;
	logic [CW-1:0]  col_s1;
	logic [RW-1:0]  row_out_s1;
	logic           last_s1;
	logic           emit_s1;
	logic           has_row_s1;
	logic           row_one_s1;
	logic [PAW-1:0] paddr_s1;

	// Accept-side decode
	logic           in_acc;
	logic           kind_in, start_in;
	logic [PW-1:0]  red_in;
	logic           restart;
	logic [CW-1:0]  pc;
	logic [RW-1:0]  pr;
	logic           tick_ok;
	logic [CW-1:0]  col_nx;
	logic [RW-1:0]  row_nx;
	logic [LAW-1:0] line_raddr;
	logic [PAW-1:0] prev_raddr;
	logic           emit_in;
	logic [RW-1:0]  row_out_in;
	logic           last_in;

	// Stage 1 datapath
	logic           s1_adv;
	logic [PW-1:0]  prev_rd, above_rd, mid_rd;
	logic [PW-1:0]  diff, above_v, low_v;
	logic [PW:0]    smoothed;
	logic           we_prev, we_above, we_mid;

	assign kind_in  = s_tuser[0];
	assign start_in = s_tuser[1];
	assign red_in   = s_tdata[PW-1:0];
	assign in_acc   = s_tvalid && s_tready;

	// Handshake: stage 1 moves on unless its result is blocked by a full output register
	assign s1_adv    = valid_s1 && (!emit_s1 || !m_tvalid || m_tready);
	assign s_tready  = !valid_s1 || s1_adv;
	assign cfg_ready = 1'b1;

	// Position and drain decode for the item on the input
	always_comb begin
		restart      = start_in || (col_q >= width_q) || (row_q >= height_q);
		pc           = restart ? '0 : col_q;
		pr           = restart ? '0 : row_q;
		tick_ok      = drain_act_q && (drain_cnt_q < width_q);
		col_nx       = pc + CW'(1);
		row_nx       = pr + RW'(1);
		col_d        = col_q;
		row_d        = row_q;
		have_prev_d  = have_prev_q;
		diff_frame_d = diff_frame_q;
		drain_act_d  = drain_act_q;
		drain_cnt_d  = drain_cnt_q;
		emit_in      = 1'b0;
		row_out_in   = pr - RW'(1);
		last_in      = 1'b0;
		if (kind_in == fdmm_pkg::KIND_TICK) begin
			row_out_in = height_q - RW'(1);
			last_in    = (drain_cnt_q == width_q - CW'(1));
			if (!tick_ok) begin
				drain_act_d = 1'b0;
			end else begin
				emit_in     = 1'b1;
				drain_cnt_d = drain_cnt_q + CW'(1);
				if (drain_cnt_d >= width_q)
					drain_act_d = 1'b0;
			end
		end else begin
			// First pixel of a frame decides whether this frame is reported
			if ((pc == '0) && (pr == '0)) begin
				diff_frame_d = have_prev_q;
				drain_act_d  = 1'b0;
				drain_cnt_d  = '0;
			end
			emit_in = diff_frame_d && (pr != '0);
			col_d   = col_nx;
			row_d   = pr;
			if (col_nx >= width_q) begin
				col_d = '0;
				row_d = row_nx;
				if (row_nx >= height_q) begin
					row_d       = '0;
					have_prev_d = 1'b1;
					if (diff_frame_d) begin
						drain_act_d = 1'b1;
						drain_cnt_d = '0;
					end
				end
			end
		end
		line_raddr = (kind_in == fdmm_pkg::KIND_TICK) ? LAW'(drain_cnt_q) : LAW'(pc);
		prev_raddr = fdmm_pkg::prev_addr(pr, pc);
	end

	// Configuration registers and sequencing state; a size write resyncs the sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= fdmm_pkg::THRESHOLD_RESET;
			width_q      <= fdmm_pkg::WIDTH_RESET;
			height_q     <= fdmm_pkg::HEIGHT_RESET;
			col_q        <= '0;
			row_q        <= '0;
			have_prev_q  <= 1'b0;
			diff_frame_q <= 1'b0;
			drain_act_q  <= 1'b0;
			drain_cnt_q  <= '0;
		end else begin
			if (in_acc) begin
				col_q        <= col_d;
				row_q        <= row_d;
				have_prev_q  <= have_prev_d;
				diff_frame_q <= diff_frame_d;
				drain_act_q  <= drain_act_d;
				drain_cnt_q  <= drain_cnt_d;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fdmm_pkg::REG_THRESHOLD: begin
						threshold_q <= cfg_data[PW-1:0];
					end
					fdmm_pkg::REG_WIDTH, fdmm_pkg::REG_HEIGHT: begin
						if (cfg_index == fdmm_pkg::REG_WIDTH)
							width_q <= fdmm_pkg::clamp_width(cfg_data[CW-1:0]);
						else
							height_q <= fdmm_pkg::clamp_height(cfg_data[RW-1:0]);
						col_q        <= '0;
						row_q        <= '0;
						have_prev_q  <= 1'b0;
						diff_frame_q <= 1'b0;
						drain_act_q  <= 1'b0;
						drain_cnt_q  <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1    <= kind_in;
			red_s1     <= red_in;
			col_s1     <= (kind_in == fdmm_pkg::KIND_TICK) ? drain_cnt_q : pc;
			row_out_s1 <= row_out_in;
			last_s1    <= last_in;
			emit_s1    <= emit_in;
			has_row_s1 <= (pr != '0);
			row_one_s1 <= (pr == RW'(1));
			paddr_s1   <= prev_raddr;
		end
	end

	// Difference, vertical filter inputs and store write-back
	always_comb begin
		diff     = (red_s1 > prev_rd) ? red_s1 - prev_rd : prev_rd - red_s1;
		above_v  = (kind_s1 == fdmm_pkg::KIND_PIXEL && row_one_s1) ? diff : above_rd;
		low_v    = (kind_s1 == fdmm_pkg::KIND_TICK) ? above_rd : diff;
		smoothed = fdmm_pkg::smooth(above_v, mid_rd, low_v);
		we_prev  = s1_adv && (kind_s1 == fdmm_pkg::KIND_PIXEL);
		we_mid   = we_prev;
		we_above = we_prev && has_row_s1;
	end

	fdmm_ram #(
		.DATA_W (PW),
		.DEPTH  (fdmm_pkg::PREV_DEPTH)
	) u_prev_ram (
		.clk   (clk),
		.we    (we_prev),
		.waddr (paddr_s1),
		.wdata (red_s1),
		.re    (in_acc),
		.raddr (prev_raddr),
		.rdata (prev_rd)
	);

	fdmm_ram #(
		.DATA_W (PW),
		.DEPTH  (fdmm_pkg::LINE_DEPTH)
	) u_above_ram (
		.clk   (clk),
		.we    (we_above),
		.waddr (LAW'(col_s1)),
		.wdata (mid_rd),
		.re    (in_acc),
		.raddr (line_raddr),
		.rdata (above_rd)
	);

	fdmm_ram #(
		.DATA_W (PW),
		.DEPTH  (fdmm_pkg::LINE_DEPTH)
	) u_mid_ram (
		.clk   (clk),
		.we    (we_mid),
		.waddr (LAW'(col_s1)),
		.wdata (diff),
		.re    (in_acc),
		.raddr (line_raddr),
		.rdata (mid_rd)
	);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (s1_adv && emit_s1)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	// Output register payload: threshold compare and position
	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			m_tdata <= {4'b0000, row_out_s1, col_s1, (smoothed > {1'b0, threshold_q})};
			m_tlast <= last_s1;
		end
	end

endmodule

`default_nettype wire
